[rtl/core/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// types and constants shared by the chunked body decoder modules
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // entries in the queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        K_BYTE        = 3'd0,
        K_FINISHED    = 3'd1,
        K_BAD_HEADER  = 3'd2,
        K_BAD_TRAILER = 3'd3,
        K_NO_HEADER   = 3'd4,
        K_TRUNCATED   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_HDR     = 3'd0,
        PH_SIZE    = 3'd1,
        PH_SIZE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRL_CR  = 3'd4,
        PH_TRL_LF  = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    // one input byte worth of results: one or two output words
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind_a;
        t_kind      kind_b;
        logic       two;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/core/hcbd_if.sv]
// ----------------------------------------------------------------------------
// hcbd interfaces
// valid/ready channels for raw response bytes and decoded results
// ----------------------------------------------------------------------------
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

[rtl/core/hcbd_front.sv]
// ----------------------------------------------------------------------------
// hcbd_front
// header search and chunk framing parser, one byte per accepted word
// ----------------------------------------------------------------------------
module hcbd_front #(
    parameter int SIZE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    output logic              o_push,
    output hcbd_pkg::t_entry  o_entry
);
    import hcbd_pkg::*;

    localparam int MAX_DIGITS = SIZE_BITS / 4;
    localparam int ACC_W      = 4 * MAX_DIGITS;
    localparam int DC_W       = $clog2(MAX_DIGITS + 1);

    t_phase             r_phase, n_phase, w_phase_mid;
    logic [1:0]         r_match, n_match;
    logic [ACC_W-1:0]   r_accum, n_accum;
    logic [ACC_W-1:0]   r_left, n_left;
    logic [DC_W-1:0]    r_digits, n_digits;

    logic       w_is_hex;
    logic [3:0] w_hex_val;
    logic       w_is_cr;
    logic       w_is_lf;
    logic       w_long;

    always_comb begin
        w_is_hex  = 1'b1;
        w_hex_val = i_byte[3:0];
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_hex_val = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            w_hex_val = i_byte[3:0] + 4'd9;
        end else begin
            w_is_hex = 1'b0;
        end
    end

    assign w_is_cr = (i_byte == CH_CR);
    assign w_is_lf = (i_byte == CH_LF);
    assign w_long  = (r_digits >= DC_W'(MAX_DIGITS));

    // next state
    always_comb begin
        w_phase_mid = r_phase;
        n_match     = r_match;
        n_accum     = r_accum;
        n_left      = r_left;
        n_digits    = r_digits;
        unique case (r_phase)
            PH_HDR: begin
                if (w_is_cr) begin
                    n_match = (r_match == 2'd2) ? 2'd3 : 2'd1;
                end else if (w_is_lf && r_match == 2'd1) begin
                    n_match = 2'd2;
                end else if (w_is_lf && r_match == 2'd3) begin
                    n_match     = 2'd0;
                    n_accum     = '0;
                    n_digits    = '0;
                    w_phase_mid = PH_SIZE;
                end else begin
                    n_match = 2'd0;
                end
            end
            PH_SIZE: begin
                if (w_is_hex) begin
                    if (w_long) begin
                        w_phase_mid = PH_DONE;
                    end else begin
                        n_accum  = {r_accum[ACC_W-5:0], w_hex_val};
                        n_digits = r_digits + DC_W'(1);
                    end
                end else if (w_is_cr) begin
                    w_phase_mid = PH_SIZE_LF;
                end else begin
                    w_phase_mid = PH_DONE;
                end
            end
            PH_SIZE_LF: begin
                if (!w_is_lf || r_accum == '0) begin
                    w_phase_mid = PH_DONE;
                end else begin
                    n_left      = r_accum;
                    w_phase_mid = PH_DATA;
                end
            end
            PH_DATA: begin
                n_left = r_left - ACC_W'(1);
                if (r_left == ACC_W'(1)) begin
                    w_phase_mid = PH_TRL_CR;
                end
            end
            PH_TRL_CR: begin
                w_phase_mid = w_is_cr ? PH_TRL_LF : PH_DONE;
            end
            PH_TRL_LF: begin
                if (w_is_lf) begin
                    n_accum     = '0;
                    n_digits    = '0;
                    w_phase_mid = PH_SIZE;
                end else begin
                    w_phase_mid = PH_DONE;
                end
            end
            default: begin
                w_phase_mid = PH_DONE;
            end
        endcase
        n_phase = w_phase_mid;
        // end of stream always returns to the reset state
        if (i_eos) begin
            n_phase  = PH_HDR;
            n_match  = 2'd0;
            n_accum  = '0;
            n_left   = '0;
            n_digits = '0;
        end
    end

    // outputs
    logic  w_res;
    t_kind w_res_kind;
    logic  w_eos_res;
    t_kind w_eos_kind;

    always_comb begin
        w_res      = 1'b0;
        w_res_kind = K_BYTE;
        unique case (r_phase)
            PH_SIZE: begin
                if ((w_is_hex && w_long) || (!w_is_hex && !w_is_cr)) begin
                    w_res      = 1'b1;
                    w_res_kind = K_BAD_HEADER;
                end
            end
            PH_SIZE_LF: begin
                if (!w_is_lf) begin
                    w_res      = 1'b1;
                    w_res_kind = K_BAD_HEADER;
                end else if (r_accum == '0) begin
                    w_res      = 1'b1;
                    w_res_kind = K_FINISHED;
                end
            end
            PH_DATA: begin
                w_res      = 1'b1;
                w_res_kind = K_BYTE;
            end
            PH_TRL_CR: begin
                w_res      = !w_is_cr;
                w_res_kind = K_BAD_TRAILER;
            end
            PH_TRL_LF: begin
                w_res      = !w_is_lf;
                w_res_kind = K_BAD_TRAILER;
            end
            default: begin
                w_res      = 1'b0;
                w_res_kind = K_BYTE;
            end
        endcase

        w_eos_res  = i_eos && (w_phase_mid != PH_DONE);
        w_eos_kind = (w_phase_mid == PH_HDR) ? K_NO_HEADER : K_TRUNCATED;

        o_push = i_acc && (w_res || w_eos_res);
        if (w_res) begin
            o_entry.out_byte = (w_res_kind == K_BYTE) ? i_byte : 8'h00;
            o_entry.kind_a   = w_res_kind;
            o_entry.kind_b   = w_eos_kind;
            o_entry.two      = w_eos_res;
        end else begin
            o_entry.out_byte = 8'h00;
            o_entry.kind_a   = w_eos_kind;
            o_entry.kind_b   = w_eos_kind;
            o_entry.two      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_match  <= 2'd0;
            r_accum  <= '0;
            r_left   <= '0;
            r_digits <= '0;
        end else if (i_acc) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_accum  <= n_accum;
            r_left   <= n_left;
            r_digits <= n_digits;
        end
    end

endmodule

[rtl/core/hcbd_queue.sv]
// ----------------------------------------------------------------------------
// hcbd_queue
// short fifo of result entries between parser and output stage
// ----------------------------------------------------------------------------
module hcbd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hcbd_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output hcbd_pkg::t_entry     o_entry,
    output hcbd_pkg::t_q_status  o_status
);
    import hcbd_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_status.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_entry        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/hcbd_back.sv]
// ----------------------------------------------------------------------------
// hcbd_back
// output register, expands each queue entry into one or two result words
// ----------------------------------------------------------------------------
module hcbd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hcbd_pkg::t_entry     i_entry,
    input  hcbd_pkg::t_q_status  i_status,
    output logic                 o_pop,
    hcbd_out_if.source           o_out
);
    import hcbd_pkg::*;

    t_entry r_ent;
    logic   r_vld;
    logic   r_half;
    logic   w_fin;
    logic   w_adv_half;

    // register empty, or current word leaves and nothing else of the entry remains
    assign w_fin      = !r_vld || (o_out.ready && (r_half || !r_ent.two));
    assign w_adv_half = r_vld && o_out.ready && !r_half && r_ent.two;
    assign o_pop      = w_fin && !i_status.empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_half <= 1'b0;
        end else if (w_adv_half) begin
            r_half <= 1'b1;
        end else if (w_fin) begin
            r_vld  <= !i_status.empty;
            r_half <= 1'b0;
        end
    end

    assign o_out.valid    = r_vld;
    assign o_out.kind     = r_half ? r_ent.kind_b : r_ent.kind_a;
    assign o_out.out_byte = r_half ? 8'h00 : r_ent.out_byte;
    assign o_out.last     = r_half || !r_ent.two;

endmodule

[rtl/core/http_chunked_body_decoder_unit.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// decodes a chunked http/1.1 response body from a raw byte stream
// ----------------------------------------------------------------------------
// i_in carries one raw response byte per word, end_of_stream on the last byte
// of a response. o_out carries body bytes (kind 0) and status words (finish,
// framing errors, no header end, truncated); last marks the final word caused
// by one input byte. A byte yields zero, one or two words.
// The parser takes one byte per cycle while the queue is not full and pushes
// its results into a four entry queue; the output stage drains one word per
// cycle from a register while the receiver is ready. Results pass through the
// queue and then the output register. Sustained rate is one byte per cycle,
// limited by receiver stalls and the output stage when bytes yield two words.
// When the receiver stalls, the queue absorbs up to four result entries plus
// one in the output register; i_in.ready drops only when the queue is full.
// Synchronous reset clears the parser to header search and empties the queue.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);
    import hcbd_pkg::*;

    logic      w_acc;
    logic      w_push;
    logic      w_pop;
    t_entry    w_push_entry;
    t_entry    w_head;
    t_q_status w_status;

    assign i_in.ready = !w_status.full;
    assign w_acc      = i_in.valid && i_in.ready;

    hcbd_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_in.in_byte),
        .i_eos   (i_in.end_of_stream),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    hcbd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_head),
        .o_status (w_status)
    );

    hcbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_status.full)
        else $error("result queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_status.empty)
        else $error("pop from empty result queue");

    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != K_BYTE) |-> (o_out.out_byte == 8'h00))
        else $error("status word with nonzero byte");

    a_eos_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == K_NO_HEADER || o_out.kind == K_TRUNCATED))
        |-> o_out.last)
        else $error("end of stream word not marked last");

endmodule

[bench/hcbd_decode_checker.sv]
// ----------------------------------------------------------------------------
// hcbd_decode_checker
// watches the raw byte and decoded word channels, decodes every accepted raw
// byte on its own and compares each decoded word with the oldest one due
// ----------------------------------------------------------------------------
module hcbd_decode_checker #(
    parameter int SIZE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hcbd_in_if   i_raw,
    hcbd_out_if  i_dec,
    output int   o_fail_count,
    output int   o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import hcbd_pkg::*;

    localparam int MAX_DIGITS = SIZE_BITS / 4;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_dec_word;

    t_dec_word            decoded_due[$];
    t_phase               stream_phase;
    logic [1:0]           crlf_seen;
    logic [SIZE_BITS-1:0] size_field;
    logic [SIZE_BITS-1:0] chunk_left;
    int                   size_digits;
    int                   fail_total = 0;

    // bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_digit_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) begin
            return {1'b1, 4'(b - 8'h30)};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            return {1'b1, 4'(b - 8'h61 + 8'd10)};
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            return {1'b1, 4'(b - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic clear_stream();
        stream_phase = PH_HDR;
        crlf_seen    = 2'd0;
        size_field   = '0;
        chunk_left   = '0;
        size_digits  = 0;
    endtask

    task automatic decode_raw_byte(input logic [7:0] b, input logic eos);
        t_dec_word  fresh[$];
        logic [4:0] hv;
        hv = hex_digit_of(b);
        case (stream_phase)
            PH_HDR: begin
                if (b == CH_CR) begin
                    crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
                end else if (b == CH_LF && crlf_seen == 2'd1) begin
                    crlf_seen = 2'd2;
                end else if (b == CH_LF && crlf_seen == 2'd3) begin
                    crlf_seen    = 2'd0;
                    size_field   = '0;
                    size_digits  = 0;
                    stream_phase = PH_SIZE;
                end else begin
                    crlf_seen = 2'd0;
                end
            end
            PH_SIZE: begin
                if (hv[4]) begin
                    if (size_digits >= MAX_DIGITS) begin
                        fresh.push_back('{8'd0, K_BAD_HEADER, 1'b0});
                        stream_phase = PH_DONE;
                    end else begin
                        size_field  = {size_field[SIZE_BITS-5:0], hv[3:0]};
                        size_digits = size_digits + 1;
                    end
                end else if (b == CH_CR) begin
                    stream_phase = PH_SIZE_LF;
                end else begin
                    fresh.push_back('{8'd0, K_BAD_HEADER, 1'b0});
                    stream_phase = PH_DONE;
                end
            end
            PH_SIZE_LF: begin
                if (b != CH_LF) begin
                    fresh.push_back('{8'd0, K_BAD_HEADER, 1'b0});
                    stream_phase = PH_DONE;
                end else if (size_field == '0) begin
                    fresh.push_back('{8'd0, K_FINISHED, 1'b0});
                    stream_phase = PH_DONE;
                end else begin
                    chunk_left   = size_field;
                    stream_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                fresh.push_back('{b, K_BYTE, 1'b0});
                chunk_left = chunk_left - SIZE_BITS'(1);
                if (chunk_left == '0) begin
                    stream_phase = PH_TRL_CR;
                end
            end
            PH_TRL_CR: begin
                if (b == CH_CR) begin
                    stream_phase = PH_TRL_LF;
                end else begin
                    fresh.push_back('{8'd0, K_BAD_TRAILER, 1'b0});
                    stream_phase = PH_DONE;
                end
            end
            PH_TRL_LF: begin
                if (b == CH_LF) begin
                    size_field   = '0;
                    size_digits  = 0;
                    stream_phase = PH_SIZE;
                end else begin
                    fresh.push_back('{8'd0, K_BAD_TRAILER, 1'b0});
                    stream_phase = PH_DONE;
                end
            end
            default: begin
                stream_phase = PH_DONE;
            end
        endcase

        // end of response before a finish or an error
        if (eos) begin
            if (stream_phase == PH_HDR) begin
                fresh.push_back('{8'd0, K_NO_HEADER, 1'b0});
            end else if (stream_phase != PH_DONE) begin
                fresh.push_back('{8'd0, K_TRUNCATED, 1'b0});
            end
            clear_stream();
        end

        if (fresh.size() > 0) begin
            fresh[fresh.size()-1].last = 1'b1;
        end
        foreach (fresh[i]) begin
            decoded_due.push_back(fresh[i]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_dec_word want;
        if (!i_rst_n) begin
            clear_stream();
            decoded_due.delete();
        end else begin
            // compare first: a word leaving now never belongs to a byte taken now
            if (i_dec.valid === 1'b1 && i_dec.ready === 1'b1) begin
                if (decoded_due.size() == 0) begin
                    $display("%0t: unexpected word: got byte %02h kind %0d last %0d",
                             $time, i_dec.out_byte, i_dec.kind, i_dec.last);
                    fail_total = fail_total + 1;
                end else begin
                    want = decoded_due.pop_front();
                    if (i_dec.out_byte !== want.data || i_dec.kind !== want.kind ||
                        i_dec.last !== want.last) begin
                        $display({"%0t: word mismatch: expected byte %02h kind %0d last %0d,",
                                  " got byte %02h kind %0d last %0d"},
                                 $time, want.data, want.kind, want.last,
                                 i_dec.out_byte, i_dec.kind, i_dec.last);
                        fail_total = fail_total + 1;
                    end
                end
            end
            if (i_raw.valid === 1'b1 && i_raw.ready === 1'b1) begin
                decode_raw_byte(i_raw.in_byte, i_raw.end_of_stream);
            end
        end
        o_fail_count <= fail_total;
        o_words_due  <= decoded_due.size();
    end

endmodule

[bench/tb_http_chunked_body_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_unit
// drives raw responses into the chunked body decoder: short directed framing
// cases, then random responses, mostly well formed with some cut, corrupted
// or misframed, under three idle mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbd_pkg::*;

    localparam int SIZE_BITS   = 32;
    localparam int SIZE_DIGITS = SIZE_BITS / 4;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        FLAW_NONE,
        FLAW_CUT,
        FLAW_SMASH,
        FLAW_LONG_SIZE,
        FLAW_EXTENSION,
        FLAW_TRAILER
    } t_flaw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcbd_in_if  raw_ch();
    hcbd_out_if dec_ch();

    int         fail_count;
    int         words_due;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         sent_bytes = 0;
    bit         hold_armed = 1'b0;
    bit         hold_done  = 1'b0;
    // bit 8 marks the last byte of a response
    logic [8:0] resp_seq[$];

    http_chunked_body_decoder_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (raw_ch),
        .o_out   (dec_ch)
    );

    hcbd_decode_checker #(
        .SIZE_BITS (SIZE_BITS)
    ) decode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_raw        (raw_ch),
        .i_dec        (dec_ch),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("http_chunked_body_decoder_unit regression: fail");
        $finish;
    end

    // receiver: random stalls, one long hold-off once armed
    initial begin
        dec_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    dec_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end else begin
                dec_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic void add_byte(input logic [7:0] b);
        resp_seq.push_back({1'b0, b});
    endfunction

    // '^' stands for CR and '~' for LF
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "^":     add_byte(CH_CR);
                "~":     add_byte(CH_LF);
                default: add_byte(s[i]);
            endcase
        end
    endfunction

    function automatic void add_hex(input int value, input int ndig);
        int nib;
        for (int i = ndig - 1; i >= 0; i--) begin
            nib = (i < 8) ? ((value >> (4 * i)) & 15) : 0;
            if (nib < 10) begin
                add_byte(8'(8'h30 + nib));
            end else begin
                add_byte(8'(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 10));
            end
        end
    endfunction

    function automatic void mark_end();
        resp_seq[resp_seq.size()-1][8] = 1'b1;
    endfunction

    function automatic void add_response(input t_flaw flaw);
        int lines;
        int len;
        int chunks;
        int flaw_at;
        int sz;
        int nd;
        int total;
        int cut;
        lines = $urandom_range(3);
        for (int l = 0; l < lines; l++) begin
            len = $urandom_range(1, 12);
            add_byte(8'($urandom_range(33, 126)));
            for (int j = 1; j < len; j++) begin
                add_byte(($urandom_range(15) == 0) ? CH_CR : 8'($urandom_range(32, 126)));
            end
            add_text("^~");
        end
        add_text((lines == 0) ? "^~^~" : "^~");

        chunks  = $urandom_range(3);
        flaw_at = $urandom_range(chunks);
        for (int c = 0; c <= chunks; c++) begin
            if (c == chunks) begin
                sz = 0;
            end else begin
                sz = ($urandom_range(7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            end
            nd    = (sz >= 16) ? 2 : 1;
            total = ($urandom_range(3) == 0) ? $urandom_range(nd, SIZE_DIGITS) : nd;
            if (flaw == FLAW_LONG_SIZE && c == flaw_at) begin
                total = SIZE_DIGITS + 1;
            end else if (c == chunks && $urandom_range(4) == 0) begin
                total = 0;
            end
            add_hex(sz, total);
            if (flaw == FLAW_EXTENSION && c == flaw_at) begin
                add_text(";q=1");
            end
            add_text("^~");
            for (int j = 0; j < sz; j++) begin
                add_byte(8'($urandom_range(255)));
            end
            if (sz > 0) begin
                add_text((flaw == FLAW_TRAILER && c == flaw_at) ? "~" : "^~");
            end
        end
        repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));

        case (flaw)
            FLAW_CUT: begin
                cut = $urandom_range(resp_seq.size() - 1);
                while (resp_seq.size() > cut + 1) begin
                    void'(resp_seq.pop_back());
                end
            end
            FLAW_SMASH: begin
                resp_seq[$urandom_range(resp_seq.size() - 1)][7:0] = 8'($urandom_range(255));
            end
            default: ;
        endcase
        mark_end();
    endfunction

    task automatic put_word(input logic [8:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            raw_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        raw_ch.valid         <= 1'b1;
        raw_ch.in_byte       <= w[7:0];
        raw_ch.end_of_stream <= w[8];
        @(posedge i_clk);
        while (!raw_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_seq();
        foreach (resp_seq[i]) begin
            put_word(resp_seq[i]);
        end
        sent_bytes = sent_bytes + resp_seq.size();
        resp_seq.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        mark_end();
        send_seq();
    endtask

    // sender holds back until every decoded word has come out
    task automatic drain();
        raw_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int tx_pct, input int rx_pct, input int quota);
        int start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = sent_bytes;
        while (sent_bytes - start < quota) begin
            if ($urandom_range(3) == 0) begin
                add_response(t_flaw'($urandom_range(FLAW_CUT, FLAW_TRAILER)));
            end else begin
                add_response(FLAW_NONE);
            end
            send_seq();
        end
        drain();
    endtask

    initial begin
        string odd_chars;
        raw_ch.valid         = 1'b0;
        raw_ch.in_byte       = 8'd0;
        raw_ch.end_of_stream = 1'b0;
        i_rst_n              = 1'b0;
        tx_idle_pct          = 25;
        rx_idle_pct          = 65;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_text("X:1^~^~1^~");
        add_byte(8'h00);
        add_text("^~0^~");
        mark_end();
        send_seq();
        // lone cr restarts the header match
        add_text("^^~^~2^~");
        add_byte(8'hFF);
        add_byte(8'h80);
        add_text("^~0^~");
        mark_end();
        send_seq();
        send_text("^~^~^~");
        send_text("^~^x^~^~0000000c^~abcdefghijkl^~A^~0123456789^~0^~");
        send_text("^~^~000000001^~zz");
        send_text("^~^~5;x^~abcde^~0^~");
        send_text("^~^~1^x");
        send_text("^~^~1^~qXz");
        send_text("^~^~1^~q^X");
        send_text("abc^~");
        send_text("^~^~3^~ab");
        send_text("^~^~1f");
        send_text("^");
        send_text("^~^~0^~zz");
        add_text("^~^~2^~");
        add_byte(8'h7F);
        add_byte(8'h01);
        add_text("^");
        mark_end();
        send_seq();
        // bytes just outside the hex digit ranges
        odd_chars = "/:@G`g";
        for (int i = 0; i < odd_chars.len(); i++) begin
            add_text("^~^~");
            add_byte(odd_chars[i]);
            mark_end();
            send_seq();
        end
        drain();

        run_random(25, 65, 120);
        run_random(65, 25, 120);
        hold_armed = 1'b1;
        run_random(0, 0, 120);

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && words_due == 0) begin
            $display("http_chunked_body_decoder_unit regression: pass");
        end else begin
            $display("http_chunked_body_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule
